/* hdl/ffba_pkg.sv */
// shared types and constants for the first-fit block allocator
`timescale 1ns / 1ps
package ffba_pkg;
  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int HEADER_BYTES_DEF = 32;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_REALLOC = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_SIZE  = 2'd1;
  localparam logic [1:0] ST_NO_MEMORY = 2'd2;
  localparam logic [1:0] ST_UNKNOWN   = 2'd3;

  localparam logic [1:0] CFG_HEAP_BASE   = 2'd0;
  localparam logic [1:0] CFG_HEAP_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_MAX_REQUEST = 2'd2;

  localparam logic [26:0] MAX_REQUEST_RST = 27'd100000000;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input word
    logic rd_issue;   // issue table read at scan index
    logic scan_clr;   // reset scan index
    logic scan_inc;   // advance scan index
    logic take_entry; // mark scanned entry used (first fit hit)
    logic grow;       // append new block at heap top
    logic free_found; // mark found entry free
    logic save_found; // remember found entry
    logic set_res_addr; // result = input address
    logic [1:0] status;
    logic set_status;
    logic out_load;
  } ffba_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic size_bad;
    logic addr_zero;
    logic scan_end;     // scan index reached entry count
    logic fit_hit;      // read entry is free and fits
    logic addr_hit;     // read entry matches address
    logic found_bigger; // found entry larger than request
    logic grow_ok;      // table not full and heap limit kept
  } ffba_sts_t;
endpackage

/* hdl/ffba_ram.sv */
// generic single-port ram with registered read
`timescale 1ns / 1ps
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* hdl/ffba_datapath.sv */
// table memory, statistics and scan datapath
`timescale 1ns / 1ps
module ffba_datapath
  import ffba_pkg::*;
#(
  parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_enable,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_write_data,
  input  logic [1:0]  in_operation,
  input  logic [26:0] in_request_size,
  input  logic [31:0] in_address,
  input  ffba_cmd_t   cmd,
  output ffba_sts_t   sts,
  output logic [31:0] out_result_address,
  output logic [1:0]  out_status,
  output logic [6:0]  out_free_block_count,
  output logic [31:0] out_free_byte_total,
  output logic [6:0]  out_block_total,
  output logic [31:0] out_allocated_byte_total,
  output logic [11:0] out_metadata_byte_total
);
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = IW + 1;
  localparam int EW = 32 + 27 + 1;

  logic [31:0] heap_base_r, heap_limit_r, heap_top_r;
  logic [26:0] max_request_r;
  logic [CW-1:0] entry_count_r, free_count_r, scan_r;
  logic [31:0] free_sum_r, used_bytes_r;
  logic [1:0]  op_r;
  logic [26:0] size_r;
  logic [31:0] addr_r;
  logic [IW-1:0] found_r;
  logic [26:0] found_size_r;
  logic        found_free_r;
  logic [31:0] res_r;
  logic [1:0]  status_r;

  logic          ram_we;
  logic [IW-1:0] ram_addr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  logic [31:0]   rd_start;
  logic [26:0]   rd_size;
  logic          rd_free;
  logic [IW-1:0] rd_idx_r;

  assign {rd_start, rd_size, rd_free} = ram_rdata;

  ffba_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_table (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // table write port: take hit (entry at rd_idx_r), grow, or free found entry
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = scan_r[IW-1:0];
    ram_wdata = '0;
    if (cmd.take_entry) begin
      ram_we    = 1'b1;
      ram_addr  = rd_idx_r;
      ram_wdata = {rd_start, rd_size, 1'b0};
    end else if (cmd.grow) begin
      ram_we    = 1'b1;
      ram_addr  = entry_count_r[IW-1:0];
      ram_wdata = {heap_top_r, size_r, 1'b0};
    end else if (cmd.free_found) begin
      ram_we    = 1'b1;
      ram_addr  = found_r;
      ram_wdata = {addr_r - 32'(HEADER_BYTES), found_size_r, 1'b1};
    end
  end

  logic [33:0] new_top;
  assign new_top = {2'b0, heap_top_r} + {7'b0, size_r} + 34'(HEADER_BYTES);

  assign sts.op           = op_r;
  assign sts.size_bad     = (size_r == 27'd0) || (size_r > max_request_r);
  assign sts.addr_zero    = (addr_r == 32'd0);
  assign sts.scan_end     = (scan_r >= entry_count_r);
  assign sts.fit_hit      = rd_free && (size_r <= rd_size);
  assign sts.addr_hit     = ({1'b0, rd_start} + 33'(HEADER_BYTES)) == {1'b0, addr_r};
  assign sts.found_bigger = size_r < found_size_r;
  assign sts.grow_ok      = (entry_count_r < CW'(MAX_BLOCKS)) &&
                            (new_top <= {2'b0, heap_limit_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r   <= '0;
      heap_limit_r  <= '1;
      max_request_r <= MAX_REQUEST_RST;
      heap_top_r    <= '0;
      entry_count_r <= '0;
      free_count_r  <= '0;
      free_sum_r    <= '0;
      used_bytes_r  <= '0;
      scan_r        <= '0;
    end else begin
      if (cfg_write_enable) begin
        unique case (cfg_index)
          CFG_HEAP_BASE: begin
            heap_base_r <= cfg_write_data;
            if (entry_count_r == '0) heap_top_r <= cfg_write_data;
          end
          CFG_HEAP_LIMIT:  heap_limit_r <= cfg_write_data;
          CFG_MAX_REQUEST: max_request_r <= cfg_write_data[26:0];
          default: ;
        endcase
      end
      if (cmd.scan_clr) scan_r <= '0;
      else if (cmd.scan_inc) scan_r <= scan_r + 1'b1;
      if (cmd.take_entry) begin
        free_count_r <= free_count_r - 1'b1;
        free_sum_r   <= free_sum_r - 32'(rd_size);
      end
      if (cmd.grow) begin
        entry_count_r <= entry_count_r + 1'b1;
        used_bytes_r  <= used_bytes_r + 32'(size_r);
        heap_top_r    <= new_top[31:0];
      end
      if (cmd.free_found && !found_free_r) begin
        free_count_r <= free_count_r + 1'b1;
        free_sum_r   <= free_sum_r + 32'(found_size_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      size_r <= in_request_size;
      addr_r <= in_address;
      res_r  <= '0;
    end
    if (cmd.rd_issue) rd_idx_r <= scan_r[IW-1:0];
    if (cmd.save_found) begin
      found_r      <= rd_idx_r;
      found_size_r <= rd_size;
      found_free_r <= rd_free;
    end
    // a reallocate may take its own free block; it is in use again until freed
    if (cmd.take_entry && (rd_idx_r == found_r)) found_free_r <= 1'b0;
    if (cmd.take_entry) res_r <= rd_start + 32'(HEADER_BYTES);
    if (cmd.grow)       res_r <= heap_top_r + 32'(HEADER_BYTES);
    if (cmd.set_res_addr) res_r <= addr_r;
    if (cmd.set_status) status_r <= cmd.status;
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_result_address       <= res_r;
      out_status               <= status_r;
      out_free_block_count     <= 7'(free_count_r);
      out_free_byte_total      <= free_sum_r;
      out_block_total          <= 7'(entry_count_r);
      out_allocated_byte_total <= used_bytes_r;
      out_metadata_byte_total  <= 12'(32'(entry_count_r) * 32'(HEADER_BYTES));
    end
  end
endmodule

/* hdl/ffba_ctrl.sv */
// sequencer for allocate, free and reallocate
`timescale 1ns / 1ps
module ffba_ctrl
  import ffba_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  ffba_sts_t sts,
  output ffba_cmd_t cmd
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_FRD    = 4'd2; // fit scan: issue read
  localparam logic [3:0] S_FCHK   = 4'd3;
  localparam logic [3:0] S_LRD    = 4'd4; // lookup scan: issue read
  localparam logic [3:0] S_LCHK   = 4'd5;
  localparam logic [3:0] S_RDEC   = 4'd6;
  localparam logic [3:0] S_FREE   = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       realloc_r, realloc_nxt; // fit scan belongs to a reallocate
  logic       out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;
  assign in_stall  = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    realloc_nxt   = realloc_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.scan_clr = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status = ST_OK;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        realloc_nxt = 1'b0;
        priority if (sts.op == OP_ALLOC) begin
          if (sts.size_bad) begin
            cmd.set_status = 1'b1; cmd.status = ST_BAD_SIZE; state_nxt = S_DONE;
          end else state_nxt = S_FRD;
        end else if (sts.op == OP_FREE) begin
          state_nxt = sts.addr_zero ? S_DONE : S_LRD;
        end else if (sts.op == OP_REALLOC) begin
          if (sts.size_bad) begin
            cmd.set_status = 1'b1; cmd.status = ST_BAD_SIZE; state_nxt = S_DONE;
          end else state_nxt = sts.addr_zero ? S_FRD : S_LRD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FRD: begin
        if (sts.scan_end) begin
          if (sts.grow_ok) begin
            cmd.grow = 1'b1;
            state_nxt = realloc_r ? S_FREE : S_DONE;
          end else begin
            cmd.set_status = 1'b1; cmd.status = ST_NO_MEMORY; state_nxt = S_DONE;
          end
        end else begin
          cmd.rd_issue = 1'b1;
          cmd.scan_inc = 1'b1;
          state_nxt = S_FCHK;
        end
      end
      S_FCHK: begin
        if (sts.fit_hit) begin
          cmd.take_entry = 1'b1;
          state_nxt = realloc_r ? S_FREE : S_DONE;
        end else state_nxt = S_FRD;
      end
      S_LRD: begin
        if (sts.scan_end) begin
          cmd.set_status = 1'b1; cmd.status = ST_UNKNOWN; state_nxt = S_DONE;
        end else begin
          cmd.rd_issue = 1'b1;
          cmd.scan_inc = 1'b1;
          state_nxt = S_LCHK;
        end
      end
      S_LCHK: begin
        if (sts.addr_hit) begin
          cmd.save_found = 1'b1;
          state_nxt = (sts.op == OP_FREE) ? S_FREE : S_RDEC;
        end else state_nxt = S_LRD;
      end
      S_RDEC: begin
        if (sts.found_bigger) begin
          cmd.set_res_addr = 1'b1; state_nxt = S_DONE;
        end else begin
          cmd.scan_clr = 1'b1;
          realloc_nxt = 1'b1;
          state_nxt = S_FRD;
        end
      end
      S_FREE: begin
        cmd.free_found = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (out_valid_r && !out_stall && !cmd.out_load) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      realloc_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      realloc_r   <= realloc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

/* hdl/first_fit_block_allocator_top.sv */
// top level of the first-fit block allocator
`timescale 1ns / 1ps
// A word for which no table entry is scanned (bad size, free of none, unused
// operation) goes from decode straight to done. Otherwise the table sits
// in a single-port ram with registered read, so each entry scanned costs
// a read state and a check state. A reallocate that must move scans the
// table twice. The output word is registered, so a waiting result does
// not block the next input word from being taken.
// Table contents are undefined after reset and only entries below the block
// count are ever read.
module first_fit_block_allocator_top
  import ffba_pkg::*;
#(
  parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_enable,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [26:0] in_request_size,
  input  logic [31:0] in_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result_address,
  output logic [1:0]  out_status,
  output logic [6:0]  out_free_block_count,
  output logic [31:0] out_free_byte_total,
  output logic [6:0]  out_block_total,
  output logic [31:0] out_allocated_byte_total,
  output logic [11:0] out_metadata_byte_total
);
  ffba_cmd_t cmd;
  ffba_sts_t sts;

  ffba_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  ffba_datapath #(.MAX_BLOCKS(MAX_BLOCKS), .HEADER_BYTES(HEADER_BYTES)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_write_enable(cfg_write_enable), .cfg_index(cfg_index),
    .cfg_write_data(cfg_write_data),
    .in_operation(in_operation), .in_request_size(in_request_size),
    .in_address(in_address), .cmd(cmd), .sts(sts),
    .out_result_address(out_result_address), .out_status(out_status),
    .out_free_block_count(out_free_block_count),
    .out_free_byte_total(out_free_byte_total),
    .out_block_total(out_block_total),
    .out_allocated_byte_total(out_allocated_byte_total),
    .out_metadata_byte_total(out_metadata_byte_total)
  );
endmodule
